// File: design/aspm_pkg.sv
// shared constants and types for the aspect scale point mapper
package aspm_pkg;

   localparam int SCALE_FRAC_BITS_DEF = 16;

   localparam int IMG_W  = 12;
   localparam int AREA_W = 16;
   localparam int PT_W   = 16;
   localparam int OUT_W  = 19;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AREA_WIDTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AREA_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_MODE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_LEFT     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_TOP      = 3'd6;

   typedef enum logic [1:0] {
      MODE_STRETCH  = 2'd0,
      MODE_FIT      = 2'd1,
      MODE_CROP     = 2'd2,
      MODE_UNSCALED = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_SEL  = 4'b1000
   } seq_state_type;

endpackage

// File: design/aspm_div.sv
// restoring divider, one quotient bit per cycle
module aspm_div
   import aspm_pkg::*;
#(
   parameter int DW = 26
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DW-1:0]     dividend,
   input  logic [IMG_W-1:0]  divisor,
   output logic [DW-1:0]     quotient
);

   logic [DW-1:0]    num_ff, num_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [IMG_W-1:0] rem_ff, rem_in;
   logic [IMG_W:0]   trial;

   always_comb begin
      trial  = {rem_ff, num_ff[DW-1]};
      num_in = {num_ff[DW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
         rem_in = IMG_W'(trial - {1'b0, divisor});
         quo_in = {quo_ff[DW-2:0], 1'b1};
      end else begin
         rem_in = trial[IMG_W-1:0];
         quo_in = {quo_ff[DW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else if (start) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         quo_ff <= '0;
      end else begin
         num_ff <= num_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient = quo_ff;

endmodule

// File: design/aspect_scale_point_mapper.sv
// Maps image-pixel points to drawing-area millimetres in stretch, fit, crop or unscaled mode.
// One point can enter every cycle while the result side does not stall and no scale rebuild runs;
// the multiply, the offset add and the round/saturate stage each hold one register level.
// After every configuration write the scales are rebuilt by two bit-serial dividers:
// the dividers are loaded and divide, then the products are registered and the scales selected,
// and throughout req_ready is low. Zero sizes, as after reset, pass points through with
// passed_through set.
module aspect_scale_point_mapper
   import aspm_pkg::*;
#(
   parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [PT_W-1:0]              req_point_x,
   input  logic [PT_W-1:0]              req_point_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [OUT_W-1:0]      rsp_out_x,
   output logic signed [OUT_W-1:0]      rsp_out_y,
   output logic                         rsp_passed_through
);

   localparam int F   = SCALE_FRAC_BITS;
   localparam int SCW = F + 10;
   localparam int PW  = PT_W + SCW;
   localparam int VW  = F + 30;
   localparam int MW  = IMG_W + SCW;
   localparam int QW  = VW - F + 1;
   localparam int CW  = $clog2(SCW + 1);
   localparam logic signed [QW-1:0] OUT_MAXV = QW'(262143);
   localparam logic signed [QW-1:0] OUT_MINV = -QW'(262144);

   logic [IMG_W-1:0]  img_w_ff, img_h_ff;
   logic [AREA_W-1:0] area_w_ff, area_h_ff, pad_l_ff, pad_t_ff;
   mode_type          mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff  <= '0;
         img_h_ff  <= '0;
         area_w_ff <= '0;
         area_h_ff <= '0;
         pad_l_ff  <= '0;
         pad_t_ff  <= '0;
         mode_ff   <= MODE_STRETCH;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  img_w_ff  <= csr_wdata[IMG_W-1:0];
            REG_IMAGE_HEIGHT: img_h_ff  <= csr_wdata[IMG_W-1:0];
            REG_AREA_WIDTH:   area_w_ff <= csr_wdata;
            REG_AREA_HEIGHT:  area_h_ff <= csr_wdata;
            REG_SCALE_MODE:   mode_ff   <= mode_type'(csr_wdata[1:0]);
            REG_PAD_LEFT:     pad_l_ff  <= csr_wdata;
            REG_PAD_TOP:      pad_t_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // scale sequencer
   seq_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          div_start;
   logic [SCW-1:0] sw_q, sh_q;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      div_start = 1'b0;
      if (csr_write_en) begin
         state_in  = ST_DIV;
         cnt_in    = '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: ;
            ST_DIV: begin
               div_start = (cnt_ff == '0);
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CW'(SCW)) state_in = ST_MUL;
            end
            ST_MUL: state_in = ST_SEL;
            ST_SEL: state_in = ST_IDLE;
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   aspm_div #(.DW(SCW)) u_div_w (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (SCW'(area_w_ff) << (F - 6)),
      .divisor  (img_w_ff),
      .quotient (sw_q)
   );

   aspm_div #(.DW(SCW)) u_div_h (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (SCW'(area_h_ff) << (F - 6)),
      .divisor  (img_h_ff),
      .quotient (sh_q)
   );

   logic [IMG_W+AREA_W-1:0] cross_a_ff, cross_b_ff;
   logic [MW-1:0]           ph_w_ff, pw_h_ff;
   logic [SCW-1:0]          sw_ff, sh_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         cross_a_ff <= IMG_W'(img_w_ff) * area_h_ff;
         cross_b_ff <= AREA_W'(area_w_ff) * img_h_ff;
         ph_w_ff    <= MW'(img_h_ff) * MW'(sw_q);
         pw_h_ff    <= MW'(img_w_ff) * MW'(sh_q);
         sw_ff      <= sw_q;
         sh_ff      <= sh_q;
      end
   end

   logic [SCW-1:0]       sx_ff, sy_ff;
   logic signed [VW-1:0] cst_x_ff, cst_y_ff;
   logic                 zero_ff;

   always_ff @(posedge clock) begin
      logic wider, use_w;
      logic signed [VW-1:0] pad_x, pad_y, off_x, off_y;
      wider = cross_a_ff > cross_b_ff;
      use_w = (mode_ff == MODE_FIT) ? wider : !wider;
      pad_x = $signed(VW'(pad_l_ff) << (F - 1));
      pad_y = $signed(VW'(pad_t_ff) << (F - 1));
      off_x = $signed(VW'(area_w_ff) << (F - 2)) - $signed(VW'(pw_h_ff) << 4);
      off_y = $signed(VW'(area_h_ff) << (F - 2)) - $signed(VW'(ph_w_ff) << 4);
      if (reset) begin
         zero_ff <= 1'b1;
      end else if (state_ff == ST_SEL) begin
         zero_ff <= (img_w_ff == '0) || (img_h_ff == '0) ||
                    (area_w_ff == '0) || (area_h_ff == '0);
         case (mode_ff) inside
            MODE_STRETCH: begin
               sx_ff <= sw_ff; sy_ff <= sh_ff;
               cst_x_ff <= pad_x; cst_y_ff <= pad_y;
            end
            MODE_FIT, MODE_CROP: begin
               if (use_w) begin
                  sx_ff <= sw_ff; sy_ff <= sw_ff;
                  cst_x_ff <= pad_x; cst_y_ff <= pad_y + off_y;
               end else begin
                  sx_ff <= sh_ff; sy_ff <= sh_ff;
                  cst_x_ff <= pad_x + off_x; cst_y_ff <= pad_y;
               end
            end
            default: begin
               sx_ff <= SCW'(1) << F; sy_ff <= SCW'(1) << F;
               cst_x_ff <= pad_x; cst_y_ff <= pad_y;
            end
         endcase
      end
   end

   // point pipeline
   logic adv;
   logic v1_ff, v2_ff, v3_ff;
   logic [PT_W-1:0] px1_ff, py1_ff, px2_ff, py2_ff;
   logic [PW-1:0]   prx_ff, pry_ff;
   logic signed [VW-1:0] vx_ff, vy_ff;
   logic signed [OUT_W-1:0] ox_ff, oy_ff;
   logic pass_ff;

   assign adv       = !v3_ff || rsp_ready;
   assign req_ready = adv && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid && req_ready;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [VW-1:0] v);
      logic signed [VW-1:0] t;
      logic signed [QW-1:0] q;
      t = v + $signed(VW'(1) << (F - 2));
      q = QW'(t >>> (F - 1));
      if (q > OUT_MAXV) round_sat = OUT_W'(OUT_MAXV);
      else if (q < OUT_MINV) round_sat = OUT_W'(OUT_MINV);
      else round_sat = q[OUT_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         px1_ff <= req_point_x;
         py1_ff <= req_point_y;
         prx_ff <= PW'(req_point_x) * PW'(sx_ff);
         pry_ff <= PW'(req_point_y) * PW'(sy_ff);
         px2_ff <= px1_ff;
         py2_ff <= py1_ff;
         vx_ff  <= $signed(VW'({prx_ff, 1'b0})) + cst_x_ff;
         vy_ff  <= $signed(VW'({pry_ff, 1'b0})) + cst_y_ff;
         pass_ff <= zero_ff;
         if (zero_ff) begin
            ox_ff <= $signed({1'b0, px2_ff, 2'b00});
            oy_ff <= $signed({1'b0, py2_ff, 2'b00});
         end else begin
            ox_ff <= round_sat(vx_ff);
            oy_ff <= round_sat(vy_ff);
         end
      end
   end

   assign rsp_valid          = v3_ff;
   assign rsp_out_x          = ox_ff;
   assign rsp_out_y          = oy_ff;
   assign rsp_passed_through = pass_ff;

endmodule

// File: dv/aspect_scale_point_mapper_tb.sv
// testbench for the aspect scale point mapper: random stimulus checked against a scoreboard
`timescale 1ns / 100ps

module aspect_scale_point_mapper_tb;
   import aspm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic                    passed;
   } mm_point_type;

   class mm_point_scoreboard;
      logic [IMG_W-1:0]  img_w, img_h;
      logic [AREA_W-1:0] area_w, area_h, pad_l, pad_t;
      mode_type          mode;
      mm_point_type      awaited[$];
      int                errors;

      function new();
         img_w = '0; img_h = '0; area_w = '0; area_h = '0;
         pad_l = '0; pad_t = '0; mode = MODE_STRETCH; errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            REG_IMAGE_WIDTH:  img_w = v[IMG_W-1:0];
            REG_IMAGE_HEIGHT: img_h = v[IMG_W-1:0];
            REG_AREA_WIDTH:   area_w = v;
            REG_AREA_HEIGHT:  area_h = v;
            REG_SCALE_MODE:   mode = mode_type'(v[1:0]);
            REG_PAD_LEFT:     pad_l = v;
            REG_PAD_TOP:      pad_t = v;
            default: ;
         endcase
      endfunction

      function longint scale_q16(longint mm, longint pix);
         return (mm <<< 16) / (pix * 64);
      endfunction

      function longint center2(longint mm, longint pix, longint s);
         return (mm <<< 14) - ((pix * s) <<< 4);
      endfunction

      function logic signed [OUT_W-1:0] round_axis(longint p, longint s, longint off2,
                                                   longint pad);
         longint v, q;
         v = 2 * p * s + 2 * (pad <<< 14) + off2;
         q = (v + (64'sd1 <<< 14)) >>> 15;
         if (q > 262143) q = 262143;
         if (q < -262144) q = -262144;
         return q[OUT_W-1:0];
      endfunction

      function void note_point(logic [PT_W-1:0] px, logic [PT_W-1:0] py);
         mm_point_type e;
         longint sw, sh, sx, sy, ox2, oy2;
         bit wider, by_width;
         ox2 = 0; oy2 = 0;
         if (img_w == 0 || img_h == 0 || area_w == 0 || area_h == 0) begin
            e.x = {1'b0, px, 2'b00};
            e.y = {1'b0, py, 2'b00};
            e.passed = 1'b1;
         end else begin
            wider = longint'(img_w) * longint'(area_h) > longint'(area_w) * longint'(img_h);
            sw = scale_q16(area_w, img_w);
            sh = scale_q16(area_h, img_h);
            case (mode) inside
               MODE_STRETCH: begin
                  sx = sw; sy = sh;
               end
               MODE_FIT, MODE_CROP: begin
                  by_width = (mode == MODE_FIT) ? wider : !wider;
                  if (by_width) begin
                     sx = sw; sy = sw;
                     oy2 = center2(area_h, img_h, sw);
                  end else begin
                     sx = sh; sy = sh;
                     ox2 = center2(area_w, img_w, sh);
                  end
               end
               default: begin
                  sx = 64'sd1 <<< 16; sy = sx;
               end
            endcase
            e.x = round_axis(px, sx, ox2, pad_l);
            e.y = round_axis(py, sy, oy2, pad_t);
            e.passed = 1'b0;
         end
         awaited = {awaited, e};
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_point(logic signed [OUT_W-1:0] x, logic signed [OUT_W-1:0] y, logic pt);
         mm_point_type e;
         if (awaited.size() == 0) begin
            report("result beat with nothing awaited");
         end else begin
            e = awaited.pop_front();
            if (x !== e.x) report($sformatf("out_x %0d, awaited %0d", x, e.x));
            if (y !== e.y) report($sformatf("out_y %0d, awaited %0d", y, e.y));
            if (pt !== e.passed) report($sformatf("passed_through %0b, awaited %0b", pt, e.passed));
         end
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [PT_W-1:0]         req_point_x = '0;
   logic [PT_W-1:0]         req_point_y = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_out_x;
   logic signed [OUT_W-1:0] rsp_out_y;
   logic                    rsp_passed_through;

   mm_point_scoreboard sb = new();
   bit quiet = 1'b0;
   bit rsp_take = 1'b0;
   int rsp_wait = 0;

   aspect_scale_point_mapper DUT (.*);

   always #2 clock = ~clock;

   // result side: sample before the edge, stall at random
   always @(negedge clock) begin
      rsp_take = !reset && rsp_valid && rsp_ready;
      if (rsp_take) sb.check_point(rsp_out_x, rsp_out_y, rsp_passed_through);
   end

   always @(posedge clock) begin
      logic nxt;
      if (rsp_take) rsp_wait = quiet ? 0 : $urandom_range(0, 14);
      if (rsp_wait > 0) begin
         rsp_wait--;
         nxt = 1'b0;
      end else begin
         nxt = 1'b1;
      end
      rsp_ready <= nxt;
   end

   task csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      sb.write_reg(idx, v);
   endtask

   task configure(int iw, int ih, int aw, int ah, mode_type m, int pl, int pt);
      csr_write(REG_IMAGE_WIDTH, CSR_DATA_W'(iw));
      csr_write(REG_IMAGE_HEIGHT, CSR_DATA_W'(ih));
      csr_write(REG_AREA_WIDTH, CSR_DATA_W'(aw));
      csr_write(REG_AREA_HEIGHT, CSR_DATA_W'(ah));
      csr_write(REG_SCALE_MODE, CSR_DATA_W'(m));
      csr_write(REG_PAD_LEFT, CSR_DATA_W'(pl));
      csr_write(REG_PAD_TOP, CSR_DATA_W'(pt));
      if ($urandom_range(0, 1)) csr_write(REG_UNUSED, CSR_DATA_W'($urandom));
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task send_point(logic [PT_W-1:0] px, logic [PT_W-1:0] py);
      int gap;
      bit acc;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      do begin
         @(negedge clock);
         acc = req_ready;
         @(posedge clock);
      end while (!acc);
      sb.note_point(px, py);
   endtask

   task drain();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task run_points(int n);
      logic [PT_W-1:0] px, py;
      send_point('0, '0);
      send_point('1, '1);
      send_point('0, '1);
      send_point('1, '0);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0: begin
               px = PT_W'($urandom); py = PT_W'($urandom);
            end
            1: begin
               px = PT_W'($urandom_range(0, 2047)); py = PT_W'($urandom_range(0, 2047));
            end
            2: begin
               px = PT_W'($urandom_range(0, 31)); py = PT_W'($urandom);
            end
            default: begin
               px = PT_W'($urandom); py = PT_W'($urandom_range(65000, 65535));
            end
         endcase
         send_point(px, py);
      end
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      run_points(20);
      configure(640, 480, 12800, 9600, MODE_STRETCH, 0, 0);
      run_points(100);
      configure(1920, 1080, 12800, 12800, MODE_FIT, 320, 640);
      run_points(100);
      configure(1080, 1920, 12800, 12800, MODE_CROP, 0, 65535);
      quiet = 1'b1;
      run_points(100);
      quiet = 1'b0;
      configure(100, 50, 6400, 3200, MODE_FIT, 1, 1);
      run_points(60);
      configure(100, 50, 6400, 3200, MODE_CROP, 1, 1);
      run_points(60);
      configure(4095, 4095, 65535, 65535, MODE_UNSCALED, 65535, 65535);
      run_points(80);
      configure(1, 1, 65535, 65535, MODE_STRETCH, 65535, 65535);
      run_points(80);
      configure(1, 4095, 65535, 1, MODE_CROP, 0, 0);
      run_points(80);
      configure(0, 480, 12800, 9600, MODE_FIT, 100, 100);
      run_points(30);
      configure(640, 0, 12800, 9600, MODE_CROP, 100, 100);
      run_points(30);
      configure(640, 480, 0, 9600, MODE_UNSCALED, 100, 100);
      run_points(30);
      configure(640, 480, 12800, 0, MODE_STRETCH, 100, 100);
      run_points(30);
      repeat (8) begin
         quiet = ($urandom_range(0, 3) == 0);
         configure($urandom_range(1, 4095), $urandom_range(1, 4095),
                   $urandom_range(1, 65535), $urandom_range(1, 65535),
                   mode_type'($urandom_range(0, 3)),
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1000),
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1000));
         run_points(120);
      end
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

endmodule

// File: sim.f
design/aspm_pkg.sv
design/aspm_div.sv
design/aspect_scale_point_mapper.sv
dv/aspect_scale_point_mapper_tb.sv
